// File: rtl/fixed_block_pool_allocator_macros.svh
// Assertion macros for the fixed block pool allocator
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Property that must hold on every clock edge out of reset
`define FBPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator
`default_nettype none

package fbpa_pkg;

  localparam int MAX_BLOCKS_DEF = 256;
  localparam int ADDR_WIDTH_DEF = 32;

  localparam int POOL_BASE_W = 32;
  localparam int BLK_BYTES_W = 16;
  localparam int BLK_COUNT_W = 9;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;

  localparam logic [POOL_BASE_W-1:0] POOL_BASE_RST = '0;
  localparam logic [BLK_BYTES_W-1:0] BLK_BYTES_RST = 16'd64;
  localparam logic [BLK_COUNT_W-1:0] BLK_COUNT_RST = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE = 2'd0,
    CFG_BLK_BYTES = 2'd1,
    CFG_BLK_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_EMPTY      = 3'd1,
    STS_NULL       = 3'd2,
    STS_MISALIGNED = 3'd3,
    STS_RANGE      = 3'd4,
    STS_NOT_USED   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ARD,
    ST_MUL,
    ST_BASE,
    ST_OFF,
    ST_DIV,
    ST_CHK,
    ST_URD,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator with a shared iterative add/subtract unit
//
//  channel   | dir | handshake               | contents
//  s_axis    | in  | s_axis_tvalid/tready    | tuser: command; tdata: address
//  m_axis    | out | m_axis_tvalid/tready    | tdata: status, block_address, block_index
//  cfg       | in  | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// Allocate pops a free index, multiplies it by the block size and adds the pool base;
// free subtracts the base, divides by the size, checks remainder and range, then reads
// the used mark; a null address or an empty pool goes straight to the result. Multiply
// is shift-add, one index bit a cycle; divide restores, one address bit a cycle. After
// reset and after each block count write a sweep refills the ring and clears the map.
// A result waits in the output register while the next request is accepted.
`default_nettype none

`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // address
  input  wire logic [((ADDR_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // command
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // status, block_address, block_index
  output logic [((3+ADDR_WIDTH+$clog2(MAX_BLOCKS)+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int W      = ADDR_WIDTH;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W  = (CNT_W > BLK_COUNT_W) ? CNT_W : BLK_COUNT_W;
  localparam int STEP_W = $clog2(W + 1);
  localparam int OUT_W  = ((3 + W + IDX_W + 7) / 8) * 8;

  // configuration registers
  logic [POOL_BASE_W-1:0] pool_base_q;
  logic [BLK_BYTES_W-1:0] blk_bytes_q;
  logic [BLK_COUNT_W-1:0] blk_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= POOL_BASE_RST;
      blk_bytes_q <= BLK_BYTES_RST;
      blk_count_q <= BLK_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POOL_BASE: pool_base_q <= cfg_wdata_i[POOL_BASE_W-1:0];
        CFG_BLK_BYTES: blk_bytes_q <= cfg_wdata_i[BLK_BYTES_W-1:0];
        CFG_BLK_COUNT: blk_count_q <= cfg_wdata_i[BLK_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] eff_total;
  logic [W-1:0]     size_w;
  logic [W-1:0]     base_w;

  always_comb begin
    if (CMP_W'(blk_count_q) > CMP_W'(MAX_BLOCKS)) begin
      eff_total = CNT_W'(MAX_BLOCKS);
    end else begin
      eff_total = CNT_W'(blk_count_q);
    end
    size_w = (blk_bytes_q == '0) ? W'(1) : W'(blk_bytes_q);
    base_w = W'(pool_base_q);
  end

  // sequencer state
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [W-1:0]       acc_q, acc_d;
  logic [W-1:0]       quo_q, quo_d;
  logic [W-1:0]       addr_q, addr_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  status_e            res_status_q, res_status_d;
  logic [W-1:0]       res_addr_q, res_addr_d;
  logic [IDX_W-1:0]   res_idx_q, res_idx_d;
  logic               out_valid_q, out_valid_d;
  logic [OUT_W-1:0]   out_data_q, out_data_d;

  // memories
  logic [IDX_W-1:0] ring_mem [MAX_BLOCKS];
  logic             used_mem [MAX_BLOCKS];
  logic [IDX_W-1:0] ring_rd_q;
  logic             used_rd_q;
  logic             ring_we, used_we, used_wd;
  logic [IDX_W-1:0] ring_wa, ring_wd, used_wa, used_ra;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    ring_rd_q <= ring_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    used_rd_q <= used_mem[used_ra];
  end

  // shared add/subtract unit
  logic [W:0] alu_a, alu_b, alu_y;
  logic       alu_sub;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_OFF: begin
        alu_a   = {1'b0, addr_q};
        alu_b   = {1'b0, base_w};
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = {acc_q, quo_q[W-1]};
        alu_b   = {1'b0, size_w};
        alu_sub = 1'b1;
      end
      ST_MUL: begin
        alu_a = {acc_q, 1'b0};
        alu_b = quo_q[W-1] ? {1'b0, size_w} : '0;
      end
      ST_BASE: begin
        alu_a = {1'b0, acc_q};
        alu_b = {1'b0, base_w};
      end
      default: ;
    endcase
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  logic [CNT_W:0]   tail_sum;
  logic [IDX_W-1:0] tail;

  always_comb begin
    tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
    if (tail_sum >= (CNT_W+1)'(MAX_BLOCKS)) begin
      tail_sum = tail_sum - (CNT_W+1)'(MAX_BLOCKS);
    end
    tail = tail_sum[IDX_W-1:0];
  end

  assign used_ra = quo_q[IDX_W-1:0];

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    head_d       = head_q;
    count_d      = count_q;
    step_d       = step_q;
    acc_d        = acc_q;
    quo_d        = quo_q;
    addr_d       = addr_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_idx_d    = res_idx_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    ring_we      = 1'b0;
    ring_wa      = clr_q;
    ring_wd      = clr_q;
    used_we      = 1'b0;
    used_wa      = clr_q;
    used_wd      = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_CLEAR: begin
        ring_we = 1'b1;
        used_we = 1'b1;
        clr_d   = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(MAX_BLOCKS - 1)) begin
          head_d  = '0;
          count_d = eff_total;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          res_status_d = STS_OK;
          res_addr_d   = '0;
          res_idx_d    = '0;
          addr_d       = s_axis_tdata[W-1:0];
          if (s_axis_tuser == CMD_ALLOC) begin
            if (count_q == '0) begin
              res_status_d = STS_EMPTY;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_ARD;
            end
          end else if (s_axis_tdata[W-1:0] == '0) begin
            res_status_d = STS_NULL;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_OFF;
          end
        end
      end
      ST_ARD: begin
        // pop the oldest free index and mark it used
        idx_d   = ring_rd_q;
        head_d  = (head_q == IDX_W'(MAX_BLOCKS - 1)) ? '0 : head_q + IDX_W'(1);
        count_d = count_q - CNT_W'(1);
        used_we = 1'b1;
        used_wa = ring_rd_q;
        used_wd = 1'b1;
        acc_d   = '0;
        quo_d   = {ring_rd_q, {(W-IDX_W){1'b0}}};
        step_d  = STEP_W'(IDX_W);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        acc_d  = alu_y[W-1:0];
        quo_d  = {quo_q[W-2:0], 1'b0};
        step_d = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          state_d = ST_BASE;
        end
      end
      ST_BASE: begin
        res_addr_d = alu_y[W-1:0];
        res_idx_d  = idx_q;
        state_d    = ST_DONE;
      end
      ST_OFF: begin
        quo_d   = alu_y[W-1:0];
        acc_d   = '0;
        step_d  = STEP_W'(W);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // restore on borrow
        if (alu_y[W]) begin
          acc_d = alu_a[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b0};
        end else begin
          acc_d = alu_y[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b1};
        end
        step_d = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (acc_q != '0) begin
          res_status_d = STS_MISALIGNED;
          state_d      = ST_DONE;
        end else if (quo_q >= W'(eff_total)) begin
          res_status_d = STS_RANGE;
          state_d      = ST_DONE;
        end else begin
          state_d = ST_URD;
        end
      end
      ST_URD: begin
        if (!used_rd_q) begin
          res_status_d = STS_NOT_USED;
        end else begin
          // clear the mark and push the index onto the ring tail
          used_we   = 1'b1;
          used_wa   = quo_q[IDX_W-1:0];
          used_wd   = 1'b0;
          ring_we   = 1'b1;
          ring_wa   = tail;
          ring_wd   = quo_q[IDX_W-1:0];
          res_idx_d = quo_q[IDX_W-1:0];
          if (count_q < CNT_W'(MAX_BLOCKS)) begin
            count_d = count_q + CNT_W'(1);
          end
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_W'({res_idx_q, res_addr_q, res_status_q});
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase

    // a new pool size restarts the refill sweep
    if (cfg_we_i && cfg_idx_i == CFG_BLK_COUNT) begin
      state_d = ST_CLEAR;
      clr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      count_q     <= count_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q        <= acc_d;
    quo_q        <= quo_d;
    addr_q       <= addr_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_idx_q    <= res_idx_d;
    out_data_q   <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `FBPA_ASSERT(a_count_le_total, state_q == ST_CLEAR || count_q <= eff_total, "count too big")
  `FBPA_ASSERT(a_rem, (state_q != ST_DIV && state_q != ST_CHK) || acc_q < size_w, "remainder")
  `FBPA_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, state_q != ST_IDLE, "still idle")
  `FBPA_ASSERT_NEXT(a_pop, state_q == ST_ARD, count_q == $past(count_q) - CNT_W'(1), "no pop")

endmodule

`default_nettype wire
